FILE: rtl/scv_pkg.sv
package scv_pkg;

    // defaults for the top level parameters
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int MAX_HALF_DEF    = 2;
    localparam int CHANNELS_DEF    = 3;
    localparam int SAMPLE_BITS_DEF = 16;

    // fixed field widths
    localparam int OUT_CH     = 3;
    localparam int RES_BITS   = 16;
    localparam int TAP_BITS   = 16;
    localparam int IDX_BITS   = 5;
    localparam int ROW_BITS   = 16;
    localparam int HALF_BITS  = 2;
    localparam int CFG_W_BITS = 11;
    localparam int CFG_H_BITS = 13;
    localparam int CFG_D_BITS = 13;
    localparam int FRAC_BITS  = 12;
    localparam int ROUND_BIAS = 2048;
    localparam logic [ROW_BITS-1:0] ROW_CAP = 16'hFFFF;

    // reset values of the configuration registers
    localparam logic [CFG_W_BITS-1:0] CFG_W_RESET    = 11'd1024;
    localparam logic [CFG_H_BITS-1:0] CFG_H_RESET    = 13'd1024;
    localparam logic [HALF_BITS-1:0]  CFG_HALF_RESET = 2'd1;

    // lane pipeline depth, window register to lane result
    localparam int LANE_LAT   = 4;
    localparam int FIFO_DEPTH = 8;

    typedef enum logic [1:0] {
        REQ_TAP   = 2'd0,
        REQ_PIXEL = 2'd1,
        REQ_FLUSH = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_HALF   = 2'd2,
        CFG_SPARE  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic valid;
        logic emit;
        logic last;
    } t_ctl;

    typedef struct packed {
        logic [OUT_CH-1:0][RES_BITS-1:0] value;
        logic                            clipped;
        logic                            last;
    } t_res;

    function automatic logic [ROW_BITS-1:0] row_inc(input logic [ROW_BITS-1:0] r);
        return (r == ROW_CAP) ? r : r + 1'b1;
    endfunction

endpackage

FILE: rtl/scv_ram.sv
module scv_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4101
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/scv_lane.sv
module scv_lane import scv_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int MAX_HALF    = MAX_HALF_DEF
) (
    input  logic                                  i_clk,
    input  logic [SAMPLE_BITS-1:0]                i_win  [(2*MAX_HALF+1)*(2*MAX_HALF+1)],
    input  logic signed [TAP_BITS-1:0]            i_coef [(2*MAX_HALF+1)*(2*MAX_HALF+1)],
    input  logic [(2*MAX_HALF+1)*(2*MAX_HALF+1)-1:0] i_mask,
    output logic [SAMPLE_BITS-1:0]                o_value,
    output logic                                  o_clip
);

    localparam int TAP_DIM   = 2 * MAX_HALF + 1;
    localparam int TAP_COUNT = TAP_DIM * TAP_DIM;
    localparam int PROD_W    = SAMPLE_BITS + TAP_BITS + 1;
    localparam int GROW_W    = $clog2(TAP_DIM) + 1;
    localparam int ROW_W     = PROD_W + GROW_W;
    localparam int ACC_W     = ROW_W + GROW_W;

    logic signed [PROD_W-1:0] n_prod [TAP_COUNT];
    logic signed [PROD_W-1:0] r_prod [TAP_COUNT];
    logic signed [ROW_W-1:0]  n_row  [TAP_DIM];
    logic signed [ROW_W-1:0]  r_row  [TAP_DIM];
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [ACC_W-1:0]  smax;
    logic [SAMPLE_BITS-1:0]   n_value;
    logic                     n_clip;
    logic [SAMPLE_BITS-1:0]   r_value;
    logic                     r_clip;

    // one multiplier per tap, masked where the neighbour is padding
    always_comb begin
        for (int t = 0; t < TAP_COUNT; t++) begin
            if (i_mask[t]) begin
                n_prod[t] = $signed({{(PROD_W-SAMPLE_BITS){1'b0}}, i_win[t]})
                          * PROD_W'(i_coef[t]);
            end else begin
                n_prod[t] = '0;
            end
        end
    end

    always_comb begin
        for (int r = 0; r < TAP_DIM; r++) begin
            n_row[r] = '0;
            for (int j = 0; j < TAP_DIM; j++) begin
                n_row[r] = n_row[r] + ROW_W'(r_prod[r*TAP_DIM+j]);
            end
        end
    end

    always_comb begin
        n_acc = '0;
        for (int r = 0; r < TAP_DIM; r++) begin
            n_acc = n_acc + ACC_W'(r_row[r]);
        end
    end

    // round half up out of q3.12, then clamp to the sample range
    assign smax = $signed({{(ACC_W-SAMPLE_BITS){1'b0}}, {SAMPLE_BITS{1'b1}}});
    assign rnd  = (r_acc + ACC_W'(ROUND_BIAS)) >>> FRAC_BITS;

    always_comb begin
        if (rnd < 0) begin
            n_value = '0;
            n_clip  = 1'b1;
        end else if (rnd > smax) begin
            n_value = '1;
            n_clip  = 1'b1;
        end else begin
            n_value = rnd[SAMPLE_BITS-1:0];
            n_clip  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= n_prod;
        r_row   <= n_row;
        r_acc   <= n_acc;
        r_value <= n_value;
        r_clip  <= n_clip;
    end

    assign o_value = r_value;
    assign o_clip  = r_clip;

endmodule

FILE: rtl/scv_merge.sv
module scv_merge import scv_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  t_ctl                i_ctl,
    input  logic [RES_BITS-1:0] i_value [OUT_CH],
    input  logic [OUT_CH-1:0]   i_clip,
    output logic                o_room,
    output logic                o_valid,
    input  logic                i_ready,
    output t_res                o_res
);

    localparam int FP_W = $clog2(FIFO_DEPTH);

    t_ctl              r_ctl [LANE_LAT];
    t_res              r_mem [FIFO_DEPTH];
    logic [FP_W-1:0]   r_wr;
    logic [FP_W-1:0]   r_rd;
    logic [FP_W:0]     r_cnt;
    logic [FP_W:0]     r_credit;
    logic [FP_W:0]     n_credit;
    logic              push;
    logic              pop;
    logic              drop;
    t_res              res_in;

    // control travels beside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LANE_LAT; s++) begin
                r_ctl[s] <= '0;
            end
        end else begin
            r_ctl[0] <= i_ctl;
            for (int s = 1; s < LANE_LAT; s++) begin
                r_ctl[s] <= r_ctl[s-1];
            end
        end
    end

    assign push = r_ctl[LANE_LAT-1].valid && r_ctl[LANE_LAT-1].emit;
    assign drop = r_ctl[LANE_LAT-1].valid && !r_ctl[LANE_LAT-1].emit;
    assign pop  = o_valid && i_ready;

    always_comb begin
        for (int c = 0; c < OUT_CH; c++) begin
            res_in.value[c] = i_value[c];
        end
        res_in.clipped = |i_clip;
        res_in.last    = r_ctl[LANE_LAT-1].last;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= res_in;
        end
    end

    // credit covers every data item in flight plus queued results
    always_comb begin
        n_credit = r_credit;
        if (i_take) n_credit = n_credit + 1'b1;
        if (pop)    n_credit = n_credit - 1'b1;
        if (drop)   n_credit = n_credit - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr     <= '0;
            r_rd     <= '0;
            r_cnt    <= '0;
            r_credit <= '0;
        end else begin
            r_credit <= n_credit;
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            if (push && !pop)      r_cnt <= r_cnt + 1'b1;
            else if (pop && !push) r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_room  = r_credit < (FP_W+1)'(FIFO_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_res   = r_mem[r_rd];

endmodule

FILE: rtl/stencil_convolution_2d_core.sv
// channel  direction  handshake                  payload
// in       input      i_in_valid / o_in_ready    req_type, tap_index, tap_value,
//                                                start_of_frame, pixel_c0..c2
// out      output     o_out_valid / i_out_ready  result_c0..c2, clipped, frame_last
// cfg      input      i_cfg_valid / o_cfg_ready  cfg_index, cfg_data
//
// one item per clock while credit lasts; results cross stage 1, window, lanes, queue
// the per-channel multiplier lanes are fully pipelined, one window per cycle
// synchronous active-low reset clears counters, taps, config and queue
// history ram is not cleared; padding masks every read outside the frame
// an 8-entry result queue with credit keeps input flowing while out stalls
module stencil_convolution_2d_core import scv_pkg::*; #(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int MAX_HALF    = MAX_HALF_DEF,
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item input
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_req_type,
    input  logic [IDX_BITS-1:0]   i_tap_index,
    input  logic signed [TAP_BITS-1:0] i_tap_value,
    input  logic                  i_start_of_frame,
    input  logic [RES_BITS-1:0]   i_pixel_c0,
    input  logic [RES_BITS-1:0]   i_pixel_c1,
    input  logic [RES_BITS-1:0]   i_pixel_c2,
    // result output
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [RES_BITS-1:0]   o_result_c0,
    output logic [RES_BITS-1:0]   o_result_c1,
    output logic [RES_BITS-1:0]   o_result_c2,
    output logic                  o_clipped,
    output logic                  o_frame_last,
    // configuration
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_D_BITS-1:0] i_cfg_data
);

    localparam int TAP_DIM    = 2 * MAX_HALF + 1;
    localparam int TAP_COUNT  = TAP_DIM * TAP_DIM;
    localparam int TAP_IDX_W  = $clog2(TAP_COUNT);
    localparam int LANES      = (CHANNELS < OUT_CH) ? CHANNELS : OUT_CH;
    localparam int DATA_W     = LANES * SAMPLE_BITS;
    localparam int LINES      = 2 * MAX_HALF;
    localparam int HIST_DEPTH = 2 * MAX_HALF * MAX_WIDTH + 2 * MAX_HALF + 1;
    localparam int HA_W       = $clog2(HIST_DEPTH);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WID_W      = $clog2(MAX_WIDTH + 1);

    // configuration registers
    logic [CFG_W_BITS-1:0] r_cfg_w;
    logic [CFG_H_BITS-1:0] r_cfg_h;
    logic [HALF_BITS-1:0]  r_cfg_half;
    logic [WID_W-1:0]      w_eff;
    logic [CFG_H_BITS-1:0] h_rows;
    logic [HALF_BITS-1:0]  h_eff;

    // stream position
    logic [COL_W-1:0]      r_col;
    logic [ROW_BITS-1:0]   r_row;
    logic                  r_done;
    logic [HA_W-1:0]       r_wp;
    logic [HA_W-1:0]       wp_new;

    logic                  take;
    logic                  is_data;
    logic                  is_tap;
    logic                  sof;
    logic [COL_W-1:0]      col0;
    logic [COL_W-1:0]      ca;
    logic [COL_W:0]        cb;
    logic [ROW_BITS-1:0]   row0;
    logic [ROW_BITS-1:0]   ra;
    logic [ROW_BITS-1:0]   rb;
    logic                  done0;
    logic signed [COL_W+1:0]    px;
    logic signed [ROW_BITS+1:0] py;
    logic                  pos_emit;
    logic                  pos_last;
    logic [DATA_W-1:0]     in_sample;
    logic [RES_BITS-1:0]   pix [OUT_CH];

    // stage 1: history read in flight
    logic                  r_s1_valid;
    logic                  r_s1_data;
    logic                  r_s1_emit;
    logic                  r_s1_last;
    logic [COL_W-1:0]      r_s1_x;
    logic [ROW_BITS-1:0]   r_s1_y;
    logic [DATA_W-1:0]     r_s1_sample;
    logic                  r_s1_tapwr;
    logic [TAP_IDX_W-1:0]  r_s1_tap_idx;
    logic signed [TAP_BITS-1:0] r_s1_tap_val;

    // stage 2: window formed
    t_ctl                  r_s2;
    logic [TAP_COUNT-1:0]  r_s2_mask;
    logic [TAP_COUNT-1:0]  mask;
    logic                  r_s2_tapwr;
    logic [TAP_IDX_W-1:0]  r_s2_tap_idx;
    logic signed [TAP_BITS-1:0] r_s2_tap_val;

    logic [DATA_W-1:0]     ram_q  [LINES];
    logic [DATA_W-1:0]     col_in [TAP_DIM];
    logic [DATA_W-1:0]     r_win  [TAP_DIM][TAP_DIM];
    logic signed [TAP_BITS-1:0] r_tap [TAP_COUNT];
    logic signed [TAP_BITS-1:0] coef  [TAP_COUNT];

    logic [SAMPLE_BITS-1:0] lane_win [LANES][TAP_COUNT];
    logic [SAMPLE_BITS-1:0] lane_val [LANES];
    logic [LANES-1:0]       lane_clip;
    logic [RES_BITS-1:0]    mrg_val  [OUT_CH];
    logic [OUT_CH-1:0]      mrg_clip;
    t_res                   out_res;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= CFG_W_RESET;
            r_cfg_h    <= CFG_H_RESET;
            r_cfg_half <= CFG_HALF_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_cfg_w    <= i_cfg_data[CFG_W_BITS-1:0];
                CFG_HEIGHT: r_cfg_h    <= i_cfg_data[CFG_H_BITS-1:0];
                CFG_HALF:   r_cfg_half <= i_cfg_data[HALF_BITS-1:0];
                default: ;
            endcase
        end
    end

    // zero means one, oversize width and half clamp to the build limits
    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = WID_W'(1);
        end else if (r_cfg_w > MAX_WIDTH) begin
            w_eff = WID_W'(MAX_WIDTH);
        end else begin
            w_eff = WID_W'(r_cfg_w);
        end
        h_rows = (r_cfg_h == '0) ? CFG_H_BITS'(1) : r_cfg_h;
        if (r_cfg_half == '0) begin
            h_eff = HALF_BITS'(1);
        end else if (r_cfg_half > MAX_HALF) begin
            h_eff = HALF_BITS'(MAX_HALF);
        end else begin
            h_eff = r_cfg_half;
        end
    end

    // ---------------- item intake ----------------
    assign take    = i_in_valid && o_in_ready;
    assign is_data = (i_req_type == REQ_PIXEL) || (i_req_type == REQ_FLUSH);
    assign is_tap  = (i_req_type == REQ_TAP);
    assign sof     = (i_req_type == REQ_PIXEL) && i_start_of_frame;

    assign pix[0] = i_pixel_c0;
    assign pix[1] = i_pixel_c1;
    assign pix[2] = i_pixel_c2;

    // flush items enter the history as zero samples
    generate
        for (genvar gl = 0; gl < LANES; gl++) begin : g_in
            assign in_sample[gl*SAMPLE_BITS +: SAMPLE_BITS] =
                (i_req_type == REQ_PIXEL) ? pix[gl][SAMPLE_BITS-1:0] : '0;
        end
    endgenerate

    // column/row step and the output position, h*W+h items behind
    always_comb begin
        col0  = sof ? '0 : r_col;
        row0  = sof ? '0 : r_row;
        done0 = sof ? 1'b0 : r_done;
        if (col0 >= w_eff) begin
            ca = '0;
            ra = row_inc(row0);
        end else begin
            ca = col0;
            ra = row0;
        end
        cb = (COL_W+1)'(ca) + (COL_W+1)'(1);
        rb = ra;
        if (cb >= w_eff) begin
            cb = '0;
            rb = row_inc(ra);
        end
        px = $signed((COL_W+2)'(ca)) - $signed((COL_W+2)'(h_eff));
        py = $signed((ROW_BITS+2)'(ra)) - $signed((ROW_BITS+2)'(h_eff));
        // wrap the column back at most h times (width can be below h)
        for (int k = 0; k < MAX_HALF; k++) begin
            if (px < 0) begin
                px = px + $signed((COL_W+2)'(w_eff));
                py = py - $signed((ROW_BITS+2)'(1));
            end
        end
        pos_emit = !done0 && (py >= 0) && (py < $signed((ROW_BITS+2)'(h_rows)));
        pos_last = (px + $signed((COL_W+2)'(1)) == $signed((COL_W+2)'(w_eff)))
                && (py + $signed((ROW_BITS+2)'(1)) == $signed((ROW_BITS+2)'(h_rows)));
    end

    assign wp_new = (r_wp == HA_W'(HIST_DEPTH - 1)) ? '0 : r_wp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_done <= 1'b0;
            r_wp   <= '0;
        end else if (take && is_data) begin
            r_wp   <= wp_new;
            r_done <= done0 || (pos_emit && pos_last);
            r_col  <= done0 ? col0 : cb[COL_W-1:0];
            r_row  <= done0 ? row0 : rb;
        end
    end

    // ---------------- history, one copy per window row above the newest ----------------
    generate
        for (genvar gk = 0; gk < LINES; gk++) begin : g_line
            logic [HA_W-1:0] off;
            logic [HA_W-1:0] raddr;
            assign off   = HA_W'((gk + 1) * w_eff);
            assign raddr = (wp_new >= off) ? wp_new - off
                                           : wp_new + HA_W'(HIST_DEPTH) - off;
            scv_ram #(
                .WIDTH (DATA_W),
                .DEPTH (HIST_DEPTH)
            ) u_ram (
                .i_clk   (i_clk),
                .i_we    (take && is_data),
                .i_waddr (wp_new),
                .i_wdata (in_sample),
                .i_re    (take && is_data),
                .i_raddr (raddr),
                .o_rdata (ram_q[gk])
            );
        end
    endgenerate

    // ---------------- stage 1 ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_data  <= 1'b0;
            r_s1_emit  <= 1'b0;
            r_s1_tapwr <= 1'b0;
        end else begin
            r_s1_valid <= take && (is_data || is_tap);
            r_s1_data  <= take && is_data;
            r_s1_emit  <= take && is_data && pos_emit;
            r_s1_tapwr <= take && is_tap && ({1'b0, i_tap_index} < TAP_COUNT);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_last    <= pos_last;
        r_s1_x       <= px[COL_W-1:0];
        r_s1_y       <= py[ROW_BITS-1:0];
        r_s1_sample  <= in_sample;
        r_s1_tap_idx <= TAP_IDX_W'(i_tap_index);
        r_s1_tap_val <= i_tap_value;
    end

    // padding mask: window row r, column j is neighbour (x+h-j, y+h-r)
    generate
        for (genvar gr = 0; gr < TAP_DIM; gr++) begin : g_mr
            for (genvar gj = 0; gj < TAP_DIM; gj++) begin : g_mc
                logic signed [COL_W+2:0]    nx;
                logic signed [ROW_BITS+2:0] ny;
                logic                       in_win;
                assign nx = $signed((COL_W+3)'(r_s1_x)) + $signed((COL_W+3)'(h_eff))
                          - $signed((COL_W+3)'(gj));
                assign ny = $signed((ROW_BITS+3)'(r_s1_y)) + $signed((ROW_BITS+3)'(h_eff))
                          - $signed((ROW_BITS+3)'(gr));
                assign in_win = ((HALF_BITS+2)'(gr) <= {1'b0, h_eff, 1'b0})
                             && ((HALF_BITS+2)'(gj) <= {1'b0, h_eff, 1'b0});
                assign mask[gr*TAP_DIM+gj] = in_win
                    && (nx >= 0) && (nx < $signed((COL_W+3)'(w_eff)))
                    && (ny >= 0) && (ny < $signed((ROW_BITS+3)'(h_rows)));
            end
        end
    endgenerate

    // ---------------- window registers (stage 2) ----------------
    assign col_in[0] = r_s1_sample;
    generate
        for (genvar gk = 0; gk < LINES; gk++) begin : g_col
            assign col_in[gk+1] = ram_q[gk];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && r_s1_data) begin
            for (int r = 0; r < TAP_DIM; r++) begin
                r_win[r][0] <= col_in[r];
                for (int j = 1; j < TAP_DIM; j++) begin
                    r_win[r][j] <= r_win[r][j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2       <= '0;
            r_s2_tapwr <= 1'b0;
        end else begin
            r_s2.valid <= r_s1_data;
            r_s2.emit  <= r_s1_emit;
            r_s2.last  <= r_s1_last;
            r_s2_tapwr <= r_s1_tapwr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_mask    <= mask;
        r_s2_tap_idx <= r_s1_tap_idx;
        r_s2_tap_val <= r_s1_tap_val;
    end

    // tap loads land in order with the pixels around them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TAP_COUNT; t++) begin
                r_tap[t] <= '0;
            end
        end else if (r_s2_tapwr) begin
            r_tap[r_s2_tap_idx] <= r_s2_tap_val;
        end
    end

    // window position (r, j) uses tap (2h-r, 2h-j) of the top-left sub-grid
    generate
        for (genvar gr = 0; gr < TAP_DIM; gr++) begin : g_cr
            for (genvar gj = 0; gj < TAP_DIM; gj++) begin : g_cc
                logic signed [TAP_BITS-1:0] cand [2**HALF_BITS];
                for (genvar gh = 0; gh < 2**HALF_BITS; gh++) begin : g_h
                    if (gh >= 1 && gh <= MAX_HALF && gr <= 2*gh && gj <= 2*gh) begin : g_on
                        assign cand[gh] = r_tap[(2*gh-gr)*TAP_DIM + (2*gh-gj)];
                    end else begin : g_off
                        assign cand[gh] = '0;
                    end
                end
                assign coef[gr*TAP_DIM+gj] = cand[h_eff];
            end
        end
    endgenerate

    // ---------------- channel lanes ----------------
    generate
        for (genvar gl = 0; gl < LANES; gl++) begin : g_lane
            for (genvar gt = 0; gt < TAP_COUNT; gt++) begin : g_tw
                assign lane_win[gl][gt] =
                    r_win[gt/TAP_DIM][gt%TAP_DIM][gl*SAMPLE_BITS +: SAMPLE_BITS];
            end
            scv_lane #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .MAX_HALF    (MAX_HALF)
            ) u_lane (
                .i_clk   (i_clk),
                .i_win   (lane_win[gl]),
                .i_coef  (coef),
                .i_mask  (r_s2_mask),
                .o_value (lane_val[gl]),
                .o_clip  (lane_clip[gl])
            );
        end
        for (genvar gc = 0; gc < OUT_CH; gc++) begin : g_pad
            if (gc < LANES) begin : g_used
                assign mrg_val[gc]  = RES_BITS'(lane_val[gc]);
                assign mrg_clip[gc] = lane_clip[gc];
            end else begin : g_zero
                assign mrg_val[gc]  = '0;
                assign mrg_clip[gc] = 1'b0;
            end
        end
    endgenerate

    // ---------------- merge and result queue ----------------
    scv_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take && is_data),
        .i_ctl   (r_s2),
        .i_value (mrg_val),
        .i_clip  (mrg_clip),
        .o_room  (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (out_res)
    );

    assign o_result_c0  = out_res.value[0];
    assign o_result_c1  = out_res.value[1];
    assign o_result_c2  = out_res.value[2];
    assign o_clipped    = out_res.clipped;
    assign o_frame_last = out_res.last;

endmodule

FILE: rtl/scv_checker.sv
module scv_checker import scv_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic [1:0]            i_req_type,
    input logic [IDX_BITS-1:0]   i_tap_index,
    input logic [TAP_BITS-1:0]   i_tap_value,
    input logic                  i_start_of_frame,
    input logic [RES_BITS-1:0]   i_pixel_c0,
    input logic [RES_BITS-1:0]   i_pixel_c1,
    input logic [RES_BITS-1:0]   i_pixel_c2,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [RES_BITS-1:0]   o_result_c0,
    input logic [RES_BITS-1:0]   o_result_c1,
    input logic [RES_BITS-1:0]   o_result_c2,
    input logic                  o_clipped,
    input logic                  o_frame_last,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [1:0]            i_cfg_index,
    input logic [CFG_D_BITS-1:0] i_cfg_data
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_result_c0) && $stable(o_result_c1)
            && $stable(o_result_c2) && $stable(o_clipped) && $stable(o_frame_last))
        else $error("result payload changed while stalled");

    // reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

    // reset frees all credit, so input is open
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready after reset");

endmodule

bind stencil_convolution_2d_core scv_checker u_scv_checker (.*);
